@@ hdl/hid_mouse_report_to_events_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the HID mouse report decoder
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HID_MOUSE_REPORT_TO_EVENTS_TOP_MACROS_SVH
`define HID_MOUSE_REPORT_TO_EVENTS_TOP_MACROS_SVH

// same-cycle implication
`define HMRE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HMRE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/hmre_pkg.sv @@
// ----------------------------------------------------------------------------
// hmre_pkg
// Types, constants and field helpers of the HID mouse report decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmre_pkg;

	localparam int MAX_X       = 4095;
	localparam int MAX_Y       = 4095;
	localparam int REPORT_BITS = 64;

	localparam int RPT_W      = 64;
	localparam int OFS_W      = 6;
	localparam int BTN_W      = 8;
	localparam int BIDX_W     = $clog2(BTN_W);
	localparam int DELTA_W    = 16;
	localparam int FW_W       = 5;
	localparam int CUR_OUT_W  = 12;
	localparam int BNUM_W     = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 6;

	localparam logic [RPT_W-1:0] LIVE_MASK = (REPORT_BITS >= RPT_W) ? {RPT_W{1'b1}} :
		RPT_W'((65'(1) << REPORT_BITS) - 65'(1));

	localparam int RESET_POS = 100;
	localparam int MAX_XY    = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
	localparam int POS_W     = ($clog2(MAX_XY + 1) < 7) ? 7 : $clog2(MAX_XY + 1);
	localparam int SUM_W     = ((POS_W > DELTA_W) ? POS_W : DELTA_W) + 2;

	localparam logic [OFS_W-1:0] RST_BTN_OFS = OFS_W'(0);
	localparam logic [3:0]       RST_BTN_W   = 4'd8;
	localparam logic [OFS_W-1:0] RST_X_OFS   = OFS_W'(8);
	localparam logic [FW_W-1:0]  RST_X_W     = FW_W'(8);
	localparam logic [OFS_W-1:0] RST_Y_OFS   = OFS_W'(16);
	localparam logic [FW_W-1:0]  RST_Y_W     = FW_W'(8);
	localparam logic [OFS_W-1:0] RST_WHL_OFS = OFS_W'(24);
	localparam logic [FW_W-1:0]  RST_WHL_W   = FW_W'(8);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BTN_OFS = 4'd0,
		REG_BTN_W   = 4'd1,
		REG_X_OFS   = 4'd2,
		REG_X_W     = 4'd3,
		REG_Y_OFS   = 4'd4,
		REG_Y_W     = 4'd5,
		REG_WHL_OFS = 4'd6,
		REG_WHL_W   = 4'd7
	} hmre_reg_t;

	typedef enum logic [1:0] {
		EV_MOVE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_SCROLL  = 2'd3
	} hmre_kind_t;

	typedef struct packed {
		logic [POS_W-1:0]   cur_x;
		logic [POS_W-1:0]   cur_y;
		logic [DELTA_W-1:0] dx;
		logic [DELTA_W-1:0] dy;
		logic [DELTA_W-1:0] wheel;
		logic [BTN_W-1:0]   buttons;
		logic [BTN_W-1:0]   changed;
	} hmre_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hmre_qstat_t;

	function automatic logic [FW_W-1:0] clamp_w(input logic [FW_W-1:0] w,
		input logic [FW_W-1:0] top);
		if (w == '0)
			return FW_W'(1);
		else if (w > top)
			return top;
		else
			return w;
	endfunction

	function automatic logic [DELTA_W-1:0] signed_field(input logic [RPT_W-1:0] rpt,
		input logic [OFS_W-1:0] ofs, input logic [FW_W-1:0] w);
		logic [RPT_W-1:0]   sh;
		logic [FW_W-1:0]    wc;
		logic [DELTA_W-1:0] mask;
		logic [DELTA_W-1:0] v;
		wc   = clamp_w(w, FW_W'(DELTA_W));
		sh   = (rpt & LIVE_MASK) >> ofs;
		mask = {DELTA_W{1'b1}} >> (FW_W'(DELTA_W) - wc);
		v    = sh[DELTA_W-1:0] & mask;
		if (|(v & (mask ^ (mask >> 1))))
			v = v | ~mask;
		return v;
	endfunction

	function automatic logic [BTN_W-1:0] button_field(input logic [RPT_W-1:0] rpt,
		input logic [OFS_W-1:0] ofs, input logic [3:0] w);
		logic [RPT_W-1:0] sh;
		logic [FW_W-1:0]  wc;
		logic [BTN_W-1:0] mask;
		wc   = clamp_w({1'b0, w}, FW_W'(BTN_W));
		sh   = (rpt & LIVE_MASK) >> ofs;
		mask = {BTN_W{1'b1}} >> (FW_W'(BTN_W) - wc);
		return sh[BTN_W-1:0] & mask;
	endfunction

	function automatic logic [BIDX_W-1:0] lowest_idx(input logic [BTN_W-1:0] m);
		logic [BIDX_W-1:0] idx;
		idx = '0;
		for (int i = BTN_W - 1; i >= 0; i--) begin
			if (m[i])
				idx = BIDX_W'(i);
		end
		return idx;
	endfunction

endpackage

@@ hdl/hmre_front.sv @@
// ----------------------------------------------------------------------------
// hmre_front
// Holds the field layout, extracts the report fields, updates cursor and
// button state and queues the reports that cause events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmre_front
	import hmre_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [RPT_W-1:0]      report_bits,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  hmre_qstat_t           qstat,
	output logic                  push,
	output hmre_entry_t           push_entry
);

	logic [OFS_W-1:0] btn_ofs_q, x_ofs_q, y_ofs_q, whl_ofs_q;
	logic [3:0]       btn_w_q;
	logic [FW_W-1:0]  x_w_q, y_w_q, whl_w_q;

	logic               v_s1;
	logic [DELTA_W-1:0] dx_s1, dy_s1, wheel_s1;
	logic [BTN_W-1:0]   buttons_s1;

	logic [POS_W-1:0] cursor_x_q, cursor_y_q;
	logic [BTN_W-1:0] prior_q;

	logic [BTN_W-1:0] changed;
	logic             has_ev;
	logic             s1_fire;
	logic [POS_W-1:0] next_x, next_y;

	function automatic logic [POS_W-1:0] move_pos(input logic [POS_W-1:0] pos,
		input logic [DELTA_W-1:0] delta, input logic signed [SUM_W-1:0] maxv);
		logic signed [SUM_W-1:0] s;
		s = signed'(SUM_W'(pos)) + SUM_W'(signed'(delta));
		if (s < 0)
			s = '0;
		else if (s > maxv)
			s = maxv;
		return POS_W'(s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_ofs_q <= RST_BTN_OFS;
			btn_w_q   <= RST_BTN_W;
			x_ofs_q   <= RST_X_OFS;
			x_w_q     <= RST_X_W;
			y_ofs_q   <= RST_Y_OFS;
			y_w_q     <= RST_Y_W;
			whl_ofs_q <= RST_WHL_OFS;
			whl_w_q   <= RST_WHL_W;
		end else if (cfg_we) begin
			case (hmre_reg_t'(cfg_index))
				REG_BTN_OFS: btn_ofs_q <= cfg_data[OFS_W-1:0];
				REG_BTN_W:   btn_w_q   <= cfg_data[3:0];
				REG_X_OFS:   x_ofs_q   <= cfg_data[OFS_W-1:0];
				REG_X_W:     x_w_q     <= cfg_data[FW_W-1:0];
				REG_Y_OFS:   y_ofs_q   <= cfg_data[OFS_W-1:0];
				REG_Y_W:     y_w_q     <= cfg_data[FW_W-1:0];
				REG_WHL_OFS: whl_ofs_q <= cfg_data[OFS_W-1:0];
				REG_WHL_W:   whl_w_q   <= cfg_data[FW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		changed  = buttons_s1 ^ prior_q;
		has_ev   = (dx_s1 != '0) || (dy_s1 != '0) || (changed != '0) || (wheel_s1 != '0);
		s1_fire  = v_s1 && (!qstat.full || !has_ev);
		push     = s1_fire && has_ev;
		in_ready = !v_s1 || s1_fire;
		next_x   = move_pos(cursor_x_q, dx_s1, SUM_W'(MAX_X));
		next_y   = move_pos(cursor_y_q, dy_s1, SUM_W'(MAX_Y));

		push_entry.cur_x   = next_x;
		push_entry.cur_y   = next_y;
		push_entry.dx      = dx_s1;
		push_entry.dy      = dy_s1;
		push_entry.wheel   = wheel_s1;
		push_entry.buttons = buttons_s1;
		push_entry.changed = changed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dx_s1      <= signed_field(report_bits, x_ofs_q, x_w_q);
			dy_s1      <= signed_field(report_bits, y_ofs_q, y_w_q);
			wheel_s1   <= signed_field(report_bits, whl_ofs_q, whl_w_q);
			buttons_s1 <= button_field(report_bits, btn_ofs_q, btn_w_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= POS_W'(RESET_POS);
			cursor_y_q <= POS_W'(RESET_POS);
			prior_q    <= '0;
		end else if (s1_fire) begin
			cursor_x_q <= next_x;
			cursor_y_q <= next_y;
			prior_q    <= buttons_s1;
		end
	end

endmodule

@@ hdl/hmre_queue.sv @@
// ----------------------------------------------------------------------------
// hmre_queue
// Short queue of decoded reports between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hid_mouse_report_to_events_top_macros.svh"

module hmre_queue
	import hmre_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  hmre_entry_t push_entry,
	input  logic        pop,
	output hmre_entry_t pop_entry,
	output hmre_qstat_t qstat
);

	hmre_entry_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QDEPTH - 1))
			return '0;
		else
			return p + QPTR_W'(1);
	endfunction

	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

	`HMRE_ASSERT_IMP(a_no_overflow, push, !qstat.full, "push into full queue")
	`HMRE_ASSERT_IMP(a_no_underflow, pop, !qstat.empty, "pop from empty queue")
	`HMRE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue count past depth")

endmodule

@@ hdl/hmre_back.sv @@
// ----------------------------------------------------------------------------
// hmre_back
// Expands one decoded report into its move, button and scroll events and
// presents them through a registered output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hid_mouse_report_to_events_top_macros.svh"

module hmre_back
	import hmre_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  hmre_qstat_t                 qstat,
	input  hmre_entry_t                 pop_entry,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  event_kind,
	output logic [BNUM_W-1:0]           button_number,
	output logic [CUR_OUT_W-1:0]        cursor_x,
	output logic [CUR_OUT_W-1:0]        cursor_y,
	output logic signed [DELTA_W-1:0]   delta_x,
	output logic signed [DELTA_W-1:0]   delta_y,
	output logic signed [DELTA_W-1:0]   wheel_delta,
	output logic                        last_of_report
);

	logic             work_v_q;
	hmre_entry_t      ent_q;
	logic             move_q, scroll_q;
	logic [BTN_W-1:0] mask_q;

	logic                 out_v_q;
	hmre_kind_t           kind_q;
	logic [BNUM_W-1:0]    bnum_q;
	logic [CUR_OUT_W-1:0] cx_q, cy_q;
	logic [DELTA_W-1:0]   dx_q, dy_q, whl_q;
	logic                 last_q;

	logic              emit, last;
	logic              move_n, scroll_n;
	logic [BTN_W-1:0]  mask_n;
	logic [BIDX_W-1:0] idx;
	hmre_kind_t        kind;

	logic work_left, btn_out, move_out;

	always_comb begin
		emit     = work_v_q && (!out_v_q || out_ready);
		idx      = lowest_idx(mask_q);
		move_n   = 1'b0;
		mask_n   = mask_q;
		scroll_n = scroll_q;
		if (move_q) begin
			kind = EV_MOVE;
		end else if (mask_q != '0) begin
			kind   = ent_q.buttons[idx] ? EV_PRESS : EV_RELEASE;
			mask_n = mask_q & (mask_q - BTN_W'(1));
		end else begin
			kind     = EV_SCROLL;
			scroll_n = 1'b0;
		end
		last = !(move_n || (mask_n != '0) || scroll_n);
		pop  = !qstat.empty && (!work_v_q || (emit && last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_v_q <= 1'b0;
			move_q   <= 1'b0;
			scroll_q <= 1'b0;
			mask_q   <= '0;
		end else if (pop) begin
			work_v_q <= 1'b1;
			move_q   <= (pop_entry.dx != '0) || (pop_entry.dy != '0);
			scroll_q <= (pop_entry.wheel != '0);
			mask_q   <= pop_entry.changed;
		end else if (emit) begin
			move_q   <= move_n;
			scroll_q <= scroll_n;
			mask_q   <= mask_n;
			if (last)
				work_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= pop_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= kind;
			bnum_q <= (kind == EV_PRESS || kind == EV_RELEASE) ?
				BNUM_W'(idx) + BNUM_W'(1) : '0;
			cx_q   <= CUR_OUT_W'(ent_q.cur_x);
			cy_q   <= CUR_OUT_W'(ent_q.cur_y);
			dx_q   <= (kind == EV_MOVE) ? ent_q.dx : '0;
			dy_q   <= (kind == EV_MOVE) ? ent_q.dy : '0;
			whl_q  <= (kind == EV_SCROLL) ? ent_q.wheel : '0;
			last_q <= last;
		end
	end

	assign out_valid      = out_v_q;
	assign event_kind     = kind_q;
	assign button_number  = bnum_q;
	assign cursor_x       = cx_q;
	assign cursor_y       = cy_q;
	assign delta_x        = signed'(dx_q);
	assign delta_y        = signed'(dy_q);
	assign wheel_delta    = signed'(whl_q);
	assign last_of_report = last_q;

	assign work_left = move_q || (mask_q != '0) || scroll_q;
	assign btn_out   = out_v_q && (kind_q == EV_PRESS || kind_q == EV_RELEASE);
	assign move_out  = out_v_q && (kind_q == EV_MOVE);

	`HMRE_ASSERT_IMP(a_work_pending, work_v_q, work_left, "active report with no event left")
	`HMRE_ASSERT_IMP(a_btn_number, btn_out, bnum_q != '0, "button event without button number")
	`HMRE_ASSERT_IMP(a_move_delta, move_out, (dx_q != '0) || (dy_q != '0), "move with zero deltas")

endmodule

@@ hdl/hid_mouse_report_to_events_top.sv @@
// A report passes stage 1, the report queue and the back end's work register before
// its first event is valid. The back end sends one event per cycle unless out_ready
// stalls it; a report without events leaves the front end without being queued.
// A two-entry report queue lets the front end keep taking reports while events drain.
// Reset: asynchronous, active low; layout registers return to their defaults, the
// cursor to 100,100 and the stored buttons to all released. No clearing pass.
// ----------------------------------------------------------------------------
// hid_mouse_report_to_events_top
// HID mouse report decoder: field extraction, cursor tracking, event output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_mouse_report_to_events_top
	import hmre_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [RPT_W-1:0]          report_bits,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                event_kind,
	output logic [BNUM_W-1:0]         button_number,
	output logic [CUR_OUT_W-1:0]      cursor_x,
	output logic [CUR_OUT_W-1:0]      cursor_y,
	output logic signed [DELTA_W-1:0] delta_x,
	output logic signed [DELTA_W-1:0] delta_y,
	output logic signed [DELTA_W-1:0] wheel_delta,
	output logic                      last_of_report
);

	hmre_qstat_t qstat;
	hmre_entry_t push_entry, pop_entry;
	logic        push, pop;

	hmre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.report_bits(report_bits),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	hmre_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (pop_entry),
		.qstat     (qstat)
	);

	hmre_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.pop_entry     (pop_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.button_number (button_number),
		.cursor_x      (cursor_x),
		.cursor_y      (cursor_y),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.wheel_delta   (wheel_delta),
		.last_of_report(last_of_report)
	);

endmodule

@@ bench/hid_mouse_report_to_events_checker.sv @@
// ----------------------------------------------------------------------------
// hid_mouse_report_to_events_checker
// Watches the layout port and both beat channels. For every accepted report it
// derives the move, button and scroll events that must follow, and compares
// each event beat in order against that list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_mouse_report_to_events_checker
	import hmre_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [RPT_W-1:0]          report_bits,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [1:0]                event_kind,
	input  logic [BNUM_W-1:0]         button_number,
	input  logic [CUR_OUT_W-1:0]      cursor_x,
	input  logic [CUR_OUT_W-1:0]      cursor_y,
	input  logic signed [DELTA_W-1:0] delta_x,
	input  logic signed [DELTA_W-1:0] delta_y,
	input  logic signed [DELTA_W-1:0] wheel_delta,
	input  logic                      last_of_report,
	output int                        fail_count,
	output int                        events_due,
	output int                        reports_seen,
	output int                        events_seen
);

	typedef struct {
		hmre_kind_t           kind;
		logic [BNUM_W-1:0]    button;
		logic [CUR_OUT_W-1:0] cur_x;
		logic [CUR_OUT_W-1:0] cur_y;
		logic [DELTA_W-1:0]   dx;
		logic [DELTA_W-1:0]   dy;
		logic [DELTA_W-1:0]   wheel;
		logic                 last;
	} mouse_event_t;

	mouse_event_t     pending_events[$];
	logic [OFS_W-1:0] btn_ofs, x_ofs, y_ofs, whl_ofs;
	logic [3:0]       btn_w;
	logic [FW_W-1:0]  x_w, y_w, whl_w;
	int               pos_x, pos_y;
	logic [BTN_W-1:0] held_buttons;
	int               err_cnt, rpt_cnt, ev_cnt;

	function automatic logic [DELTA_W-1:0] slice_bits(input logic [RPT_W-1:0] rpt,
		input logic [OFS_W-1:0] ofs, input int w);
		logic [RPT_W-1:0] sh;
		sh = (rpt & LIVE_MASK) >> ofs;
		return sh[DELTA_W-1:0] & DELTA_W'((32'd1 << w) - 1);
	endfunction

	function automatic int signed_slice(input logic [RPT_W-1:0] rpt,
		input logic [OFS_W-1:0] ofs, input logic [FW_W-1:0] wreg);
		int w;
		int v;
		w = (wreg == '0) ? 1 : ((wreg > DELTA_W) ? DELTA_W : int'(wreg));
		v = int'(slice_bits(rpt, ofs, w));
		if (((v >> (w - 1)) & 1) != 0)
			v = v - (1 << w);
		return v;
	endfunction

	function automatic int clamp_pos(input int p, input int top);
		if (p < 0)
			return 0;
		if (p > top)
			return top;
		return p;
	endfunction

	task automatic write_layout(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_BTN_OFS: btn_ofs = val;
			REG_BTN_W:   btn_w   = val[3:0];
			REG_X_OFS:   x_ofs   = val;
			REG_X_W:     x_w     = val[FW_W-1:0];
			REG_Y_OFS:   y_ofs   = val;
			REG_Y_W:     y_w     = val[FW_W-1:0];
			REG_WHL_OFS: whl_ofs = val;
			REG_WHL_W:   whl_w   = val[FW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic decode_report(input logic [RPT_W-1:0] rpt);
		mouse_event_t     evs[$];
		mouse_event_t     e;
		int               dx, dy, wh, bw;
		logic [BTN_W-1:0] btns, chg;
		dx = signed_slice(rpt, x_ofs, x_w);
		dy = signed_slice(rpt, y_ofs, y_w);
		wh = signed_slice(rpt, whl_ofs, whl_w);
		bw = (btn_w == '0) ? 1 : ((btn_w > BTN_W) ? BTN_W : int'(btn_w));
		btns = BTN_W'(slice_bits(rpt, btn_ofs, bw));
		chg = btns ^ held_buttons;
		pos_x = clamp_pos(pos_x + dx, MAX_X);
		pos_y = clamp_pos(pos_y + dy, MAX_Y);
		e.cur_x = CUR_OUT_W'(pos_x);
		e.cur_y = CUR_OUT_W'(pos_y);
		e.last = 1'b0;
		e.button = '0;
		e.wheel = '0;
		if (dx != 0 || dy != 0) begin
			e.kind = EV_MOVE;
			e.dx = DELTA_W'(dx);
			e.dy = DELTA_W'(dy);
			evs.push_back(e);
		end
		e.dx = '0;
		e.dy = '0;
		for (int b = 0; b < BTN_W; b++) begin
			if (chg[b]) begin
				e.kind = btns[b] ? EV_PRESS : EV_RELEASE;
				e.button = BNUM_W'(b + 1);
				evs.push_back(e);
			end
		end
		held_buttons = btns;
		if (wh != 0) begin
			e.kind = EV_SCROLL;
			e.button = '0;
			e.wheel = DELTA_W'(wh);
			evs.push_back(e);
		end
		foreach (evs[i]) begin
			e = evs[i];
			e.last = (i == evs.size() - 1);
			pending_events.push_back(e);
		end
		rpt_cnt++;
	endtask

	task automatic match_event();
		mouse_event_t e;
		if (pending_events.size() == 0) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("%0t unexpected event: kind=%0d btn=%0d x=%0d y=%0d last=%0b",
					$time, event_kind, button_number, cursor_x, cursor_y, last_of_report);
		end else begin
			e = pending_events.pop_front();
			ev_cnt++;
			if (event_kind !== e.kind || button_number !== e.button ||
				cursor_x !== e.cur_x || cursor_y !== e.cur_y ||
				delta_x !== e.dx || delta_y !== e.dy ||
				wheel_delta !== e.wheel || last_of_report !== e.last) begin
				err_cnt++;
				if (err_cnt <= 10) begin
					$display("%0t event mismatch, exp: kind=%0d btn=%0d x=%0d y=%0d dx=%0d dy=%0d wh=%0d last=%0b",
						$time, e.kind, e.button, e.cur_x, e.cur_y, $signed(e.dx),
						$signed(e.dy), $signed(e.wheel), e.last);
					$display("%0t event mismatch, got: kind=%0d btn=%0d x=%0d y=%0d dx=%0d dy=%0d wh=%0d last=%0b",
						$time, event_kind, button_number, cursor_x, cursor_y, delta_x,
						delta_y, wheel_delta, last_of_report);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_ofs = RST_BTN_OFS;
			btn_w = RST_BTN_W;
			x_ofs = RST_X_OFS;
			x_w = RST_X_W;
			y_ofs = RST_Y_OFS;
			y_w = RST_Y_W;
			whl_ofs = RST_WHL_OFS;
			whl_w = RST_WHL_W;
			pos_x = RESET_POS;
			pos_y = RESET_POS;
			held_buttons = '0;
			pending_events.delete();
			err_cnt = 0;
			rpt_cnt = 0;
			ev_cnt = 0;
			fail_count <= 0;
			events_due <= 0;
			reports_seen <= 0;
			events_seen <= 0;
		end else begin
			if (out_valid && out_ready)
				match_event();
			if (in_valid && in_ready)
				decode_report(report_bits);
			if (cfg_we)
				write_layout(cfg_index, cfg_data);
			fail_count <= err_cnt;
			events_due <= pending_events.size();
			reports_seen <= rpt_cnt;
			events_seen <= ev_cnt;
		end
	end

endmodule

@@ bench/hid_mouse_report_to_events_top_tb.sv @@
// ----------------------------------------------------------------------------
// hid_mouse_report_to_events_top_tb
// Drives mouse reports and field layouts into the decoder, throttles both
// channels at random, holds the event channel off once for a long stretch,
// and reports the verdict from the checker's failure and pending-event counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_mouse_report_to_events_top_tb;
	import hmre_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYC    = 300;
	localparam int N_PHASES    = 5;
	localparam int PHASE_ITEMS = 50;
	localparam int FLD_BTN     = 0;
	localparam int FLD_X       = 1;
	localparam int FLD_Y       = 2;
	localparam int FLD_WHL     = 3;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [RPT_W-1:0]          report_bits;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      out_valid;
	logic                      out_ready;
	logic [1:0]                event_kind;
	logic [BNUM_W-1:0]         button_number;
	logic [CUR_OUT_W-1:0]      cursor_x;
	logic [CUR_OUT_W-1:0]      cursor_y;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;
	logic signed [DELTA_W-1:0] wheel_delta;
	logic                      last_of_report;

	int               fail_count, events_due, reports_seen, events_seen;
	int               stall_cnt, layouts;
	logic             hold_req, quiet;
	logic [OFS_W-1:0] lay_ofs[4];
	int               lay_w[4];
	logic [BTN_W-1:0] btn_guess;

	hid_mouse_report_to_events_top u_dut (.*);

	hid_mouse_report_to_events_checker u_chk (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		logic held;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				// hold the event channel off while reports keep coming
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end
			out_ready <= quiet || ($urandom_range(99) >= 24);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int f, w;
		f = int'(idx) / 2;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx <= REG_WHL_W) begin
			if (idx[0] == 1'b0) begin
				lay_ofs[f] = val;
			end else begin
				w = (f == FLD_BTN) ? int'(val[3:0]) : int'(val[FW_W-1:0]);
				if (w == 0)
					lay_w[f] = 1;
				else if (f == FLD_BTN && w > BTN_W)
					lay_w[f] = BTN_W;
				else if (w > DELTA_W)
					lay_w[f] = DELTA_W;
				else
					lay_w[f] = w;
			end
		end
		@(posedge clk);
	endtask

	task automatic load_layout(input logic [CFG_DATA_W-1:0] bo, input logic [CFG_DATA_W-1:0] bw,
		input logic [CFG_DATA_W-1:0] xo, input logic [CFG_DATA_W-1:0] xw,
		input logic [CFG_DATA_W-1:0] yo, input logic [CFG_DATA_W-1:0] yw,
		input logic [CFG_DATA_W-1:0] wo, input logic [CFG_DATA_W-1:0] ww);
		write_reg(REG_BTN_OFS, bo);
		write_reg(REG_BTN_W, bw);
		write_reg(REG_X_OFS, xo);
		write_reg(REG_X_W, xw);
		write_reg(REG_Y_OFS, yo);
		write_reg(REG_Y_W, yw);
		write_reg(REG_WHL_OFS, wo);
		write_reg(REG_WHL_W, ww);
		write_reg(CFG_IDX_W'(int'(REG_WHL_W) + 1 + $urandom_range(6)), CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		layouts++;
	endtask

	task automatic offer_report(input logic [RPT_W-1:0] r);
		if (!quiet && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		report_bits <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_events(input int tail);
		in_valid <= 1'b0;
		do @(posedge clk); while (events_due != 0);
		repeat (tail) @(posedge clk);
	endtask

	function automatic logic [RPT_W-1:0] place_field(input logic [RPT_W-1:0] r, input int f,
		input int val);
		logic [RPT_W-1:0] m;
		m = RPT_W'((64'd1 << lay_w[f]) - 64'd1) << lay_ofs[f];
		return (r & ~m) | ((RPT_W'(val) << lay_ofs[f]) & m);
	endfunction

	task automatic next_report(output logic [RPT_W-1:0] r);
		int               pick;
		logic [RPT_W-1:0] sparse;
		pick = $urandom_range(99);
		sparse = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
		if (pick < 55) begin
			r = (pick < 10) ? sparse : '0;
			if ($urandom_range(99) < 40)
				btn_guess = btn_guess ^ BTN_W'(1 << $urandom_range(BTN_W - 1));
			r = place_field(r, FLD_BTN, btn_guess);
			r = place_field(r, FLD_X, int'($urandom_range(32)) - 16);
			r = place_field(r, FLD_Y, int'($urandom_range(32)) - 16);
			r = place_field(r, FLD_WHL,
				($urandom_range(99) < 30) ? int'($urandom_range(6)) - 3 : 0);
		end else if (pick < 80) begin
			r = {$urandom, $urandom};
		end else if (pick < 92) begin
			r = sparse;
		end else begin
			r = '0;
		end
	endtask

	initial begin
		logic [RPT_W-1:0] r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		report_bits = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		quiet = 1'b0;
		layouts = 1;
		btn_guess = '0;
		lay_ofs[FLD_BTN] = RST_BTN_OFS;
		lay_ofs[FLD_X] = RST_X_OFS;
		lay_ofs[FLD_Y] = RST_Y_OFS;
		lay_ofs[FLD_WHL] = RST_WHL_OFS;
		lay_w[FLD_BTN] = int'(RST_BTN_W);
		lay_w[FLD_X] = int'(RST_X_W);
		lay_w[FLD_Y] = int'(RST_Y_W);
		lay_w[FLD_WHL] = int'(RST_WHL_W);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_report(64'h0000_0000_0000_0000);
		offer_report(64'h0000_0000_0000_7F00);
		offer_report(64'h0000_0000_0080_8000);
		offer_report(64'h0000_0000_0000_00FF);
		offer_report(64'h0000_0000_0000_0000);
		offer_report(64'h0000_0000_8101_7FFF);
		offer_report(64'hFFFF_FFFF_0000_0000);
		offer_report(64'h0000_0000_0100_0000);
		offer_report(64'h0000_0000_8000_0000);
		offer_report(64'h0000_0000_00FF_0000);
		offer_report(64'h0000_0000_0000_0055);
		offer_report(64'h0000_0000_0000_00AA);
		offer_report(64'hFFFF_FFFF_FFFF_FFFF);
		offer_report(64'hFFFF_FFFF_FFFF_FFFF);
		drain_events(12);

		// widest fields, high offsets, width values above range
		load_layout(6'd56, 6'h3F, 6'd0, 6'd16, 6'd16, 6'd16, 6'd63, 6'h3F);
		offer_report(64'h0000_0000_7FFF_7FFF);
		offer_report(64'h8000_0000_8000_8000);
		offer_report(64'h7F00_0000_0000_0001);
		offer_report(64'h0000_0000_0000_0000);
		drain_events(12);

		// zero and single-bit widths at the report end
		load_layout(6'd63, 6'd0, 6'd62, 6'h20, 6'd63, 6'd1, 6'd0, 6'd2);
		offer_report(64'h8000_0000_0000_0000);
		offer_report(64'h4000_0000_0000_0003);
		offer_report(64'h0000_0000_0000_0001);
		offer_report(64'hC000_0000_0000_0002);
		drain_events(12);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p == 0)
				load_layout(RST_BTN_OFS, CFG_DATA_W'(RST_BTN_W), RST_X_OFS, CFG_DATA_W'(RST_X_W),
					RST_Y_OFS, CFG_DATA_W'(RST_Y_W), RST_WHL_OFS, CFG_DATA_W'(RST_WHL_W));
			else
				load_layout(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
			if (p == 1)
				hold_req <= 1'b1;
			if (p == 3)
				quiet <= 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == 40)
					quiet <= 1'b0;
				next_report(r);
				offer_report(r);
			end
			drain_events(12);
		end

		drain_events(40);
		$display("Covered %0d reports and %0d events over %0d field layouts,",
			reports_seen, events_seen, layouts);
		$display("with random throttling, a quiet stretch and one long event hold-off.");
		if (fail_count == 0 && events_due == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
